FILE: src/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZW code decoder: payload structs and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int CODE_W        = 12;  // width of an input code
  localparam int CFG_W         = 4;   // width of the code_bits register
  localparam int LITERALS      = 256; // codes below this are plain bytes
  localparam int MIN_CODE_BITS = 8;
  localparam logic [CFG_W-1:0] CODE_BITS_RESET = 4'd12;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_LITERAL = 2'd1,
    ST_TOO_LONG    = 2'd2
  } result_status_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic              stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic           accept;
    logic           first_lit;
    logic           set_single;
    result_status_t single_status;
    logic           walk_init;
    logic           walk;
    logic           push_lit;
    logic           update;
    logic           emit_issue;
    logic           single_issue;
  } dp_cmd_t;

  typedef struct packed {
    logic is_first;
    logic code_lit;
    logic cur_lit;
    logic at_limit;
    logic credit;
    logic k_last;
  } dp_status_t;

endpackage

FILE: src/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lzwd_datapath.sv
// ----------------------------------------------------------------------------
// lzwd_datapath
// Dictionary, string stack, decoder state registers and a two-entry output
// queue. Acts on commands from the controller and on code_bits writes.
// ----------------------------------------------------------------------------
module lzwd_datapath
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS  = 12,
  parameter int MAX_STRING_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         code_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  output dp_status_t       stat,
  output logic             byte_valid,
  input  logic             byte_stall,
  output out_item_t        byte_item
);

  localparam int CW          = MAX_CODE_BITS;
  localparam int NW          = CW + 1;
  localparam int XW          = (NW > CODE_W) ? NW : CODE_W;
  localparam int STORE_DEPTH = (2 ** CW) - LITERALS;
  localparam int DAW         = $clog2(STORE_DEPTH);
  localparam int NCW         = $clog2(MAX_STRING_LEN + 1);
  localparam int SAW         = $clog2(MAX_STRING_LEN);

  // Decoder state
  logic [CFG_W-1:0]  code_bits;
  logic [NW-1:0]     nfc;
  logic [CW-1:0]     prev_code;
  logic [7:0]        prev_first;
  logic              have_prev;

  // Per-item working registers
  logic [CODE_W-1:0] code_reg;
  logic              start_reg;
  logic              known_reg;
  logic [CW-1:0]     cur_reg;
  logic              pend;
  logic [NCW-1:0]    n;
  logic [NCW-1:0]    k;
  logic [NCW-1:0]    total;
  logic [7:0]        lit;
  logic [7:0]        first_byte;
  logic [7:0]        single_byte;
  result_status_t    single_status;

  // Emit token, registered before it enters the queue
  logic              tok_valid;
  logic              tok_const;
  logic              tok_last;
  logic [7:0]        tok_byte;
  result_status_t    tok_status;

  // Output queue
  out_item_t         q0;
  out_item_t         q1;
  logic [1:0]        cnt;

  logic [XW-1:0]     code_ext;
  logic [XW-1:0]     nfc_ext;
  logic              known;
  logic [CW-1:0]     code0;
  logic [CW+7:0]     dict_rdata;
  logic [CW-1:0]     cur;
  logic              cur_lit;
  logic [CW-1:0]     cur_off;
  logic [NW-1:0]     nfc_off;
  logic [NCW-1:0]    n_eff;
  logic [NCW-1:0]    limit;
  logic [NCW-1:0]    rd_idx;
  logic [4:0]        cb;
  logic [NW-1:0]     cap;
  logic              full;
  logic [7:0]        first_c;
  logic              dict_we;
  logic              dict_re;
  logic              stk_we;
  logic [7:0]        stk_wdata;
  logic [7:0]        stk_rdata;
  logic              take;
  logic [2:0]        occ;
  out_item_t         push_item;

  assign code_ext = XW'(code_reg);
  assign nfc_ext  = XW'(nfc);
  assign known    = code_ext < nfc_ext;
  assign code0    = code_ext[CW-1:0];

  // While a dictionary read is pending, the chain continues at its prefix.
  assign cur      = pend ? dict_rdata[CW+7:8] : cur_reg;
  assign cur_lit  = cur < CW'(LITERALS);
  assign cur_off  = cur - CW'(LITERALS);
  assign nfc_off  = nfc - NW'(LITERALS);
  assign n_eff    = n + NCW'(pend);
  assign limit    = known_reg ? NCW'(MAX_STRING_LEN) : NCW'(MAX_STRING_LEN - 1);
  assign rd_idx   = n - NCW'(1) - k;

  always_comb begin
    if (code_bits < CFG_W'(MIN_CODE_BITS)) begin
      cb = 5'(MIN_CODE_BITS);
    end else if (int'(code_bits) > CW) begin
      cb = 5'(CW);
    end else begin
      cb = {1'b0, code_bits};
    end
  end

  assign cap     = NW'(1) << cb;
  assign full    = nfc >= cap;
  assign first_c = known_reg ? lit : prev_first;

  assign dict_we   = cmd.update && !full;
  assign dict_re   = cmd.walk && !cur_lit;
  assign stk_we    = (cmd.walk && pend) || cmd.push_lit;
  assign stk_wdata = cmd.push_lit ? lit : dict_rdata[7:0];

  lzwd_ram #(
    .WIDTH (CW + 8),
    .DEPTH (STORE_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (nfc_off[DAW-1:0]),
    .wdata ({prev_code, first_c}),
    .re    (dict_re),
    .raddr (cur_off[DAW-1:0]),
    .rdata (dict_rdata)
  );

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_STRING_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (n[SAW-1:0]),
    .wdata (stk_wdata),
    .re    (cmd.emit_issue),
    .raddr (rd_idx[SAW-1:0]),
    .rdata (stk_rdata)
  );

  assign take       = byte_valid && !byte_stall;
  assign byte_valid = cnt != 2'd0;
  assign byte_item  = q0;

  // A token issued now is registered before it lands in the queue, so leave room for it.
  assign occ = 3'(cnt) + 3'(tok_valid) - 3'(take);

  assign stat.is_first = start_reg || !have_prev;
  assign stat.code_lit = code_reg < CODE_W'(LITERALS);
  assign stat.cur_lit  = cur_lit;
  assign stat.at_limit = n_eff >= limit;
  assign stat.credit   = occ <= 3'd1;
  assign stat.k_last   = k == (total - NCW'(1));

  always_comb begin
    push_item.out_byte  = tok_const ? tok_byte : stk_rdata;
    push_item.last_byte = tok_last;
    push_item.status    = tok_status;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits  <= CODE_BITS_RESET;
      nfc        <= NW'(LITERALS);
      prev_code  <= '0;
      prev_first <= '0;
      have_prev  <= 1'b0;
      pend       <= 1'b0;
      tok_valid  <= 1'b0;
      cnt        <= 2'd0;
    end else begin
      if (cfg_we) begin
        code_bits <= cfg_data;
      end
      if (cmd.first_lit) begin
        nfc        <= NW'(LITERALS);
        prev_code  <= CW'(code_reg[7:0]);
        prev_first <= code_reg[7:0];
        have_prev  <= 1'b1;
      end
      if (cmd.update) begin
        if (!full) begin
          prev_code  <= known_reg ? code0 : nfc[CW-1:0];
          prev_first <= first_c;
          nfc        <= nfc + NW'(1);
        end else if (known_reg) begin
          prev_code  <= code0;
          prev_first <= first_c;
        end
      end
      if (cmd.walk_init) begin
        pend <= 1'b0;
      end else if (cmd.walk) begin
        pend <= !cur_lit && !stat.at_limit;
      end
      tok_valid <= cmd.emit_issue || cmd.single_issue;
      cnt       <= 2'(occ);
    end
  end

  // Working registers and payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_reg  <= code_item.code_word;
      start_reg <= code_item.stream_start;
    end
    if (cmd.set_single) begin
      single_status <= cmd.single_status;
      single_byte   <= (cmd.single_status == ST_OK) ? code_reg[7:0] : 8'd0;
    end
    if (cmd.walk_init) begin
      known_reg <= known;
      cur_reg   <= known ? code0 : prev_code;
      n         <= '0;
    end
    if (cmd.walk) begin
      cur_reg <= cur;
      n       <= n_eff;
      if (cur_lit) begin
        lit <= cur[7:0];
      end
    end
    if (cmd.push_lit) begin
      n <= n + NCW'(1);
    end
    if (cmd.update) begin
      first_byte <= first_c;
      total      <= n + NCW'(!known_reg);
      k          <= '0;
    end
    if (cmd.emit_issue) begin
      k          <= k + NCW'(1);
      tok_const  <= k == n;
      tok_byte   <= first_byte;
      tok_status <= ST_OK;
      tok_last   <= stat.k_last;
    end
    if (cmd.single_issue) begin
      tok_const  <= 1'b1;
      tok_byte   <= single_byte;
      tok_status <= single_status;
      tok_last   <= 1'b1;
    end
    if (tok_valid && (cnt - 2'(take)) == 2'd0) begin
      q0 <= push_item;
    end else if (take) begin
      q0 <= q1;
    end
    if (tok_valid && (cnt - 2'(take)) != 2'd0) begin
      q1 <= push_item;
    end
  end

endmodule

FILE: src/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer of the LZW code decoder: accepts a code, walks its prefix chain,
// updates the dictionary and issues the decoded bytes, or a single status byte.
// ----------------------------------------------------------------------------
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       code_valid,
  output logic       code_stall,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_LAST   = 7'b0001000,
    S_UPDATE = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_SINGLE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign code_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (code_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_first) begin
          cmd.set_single = 1'b1;
          if (stat.code_lit) begin
            cmd.first_lit     = 1'b1;
            cmd.single_status = ST_OK;
          end else begin
            cmd.single_status = ST_NOT_LITERAL;
          end
          state_next = S_SINGLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.cur_lit) begin
          state_next = S_LAST;
        end else if (stat.at_limit) begin
          cmd.set_single    = 1'b1;
          cmd.single_status = ST_TOO_LONG;
          state_next        = S_SINGLE;
        end
      end
      S_LAST: begin
        // The literal at the root of the chain still has to fit.
        if (stat.at_limit) begin
          cmd.set_single    = 1'b1;
          cmd.single_status = ST_TOO_LONG;
          state_next        = S_SINGLE;
        end else begin
          cmd.push_lit = 1'b1;
          state_next   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.credit) begin
          cmd.emit_issue = 1'b1;
          if (stat.k_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (stat.credit) begin
          cmd.single_issue = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/lzw_code_decoder_top.sv
// ----------------------------------------------------------------------------
// lzw_code_decoder_top
// LZW decoder: one code per input item, the decoded string one byte per
// output item, first byte first, last byte marked.
//
//   channel  handshake              payload
//   code     code_valid/code_stall  in_item_t  (code_word, stream_start)
//   byte     byte_valid/byte_stall  out_item_t (out_byte, last_byte, status)
//   cfg      cfg_valid/cfg_ready    code_bits, 4 bits
//
// A code is accepted, its prefix chain is walked link by link through the
// dictionary RAM, the dictionary is updated, and then the string leaves the
// string stack RAM one byte per cycle while the output queue has room. First
// codes and first-code errors give a single byte with their status; an
// overlong string is given up with a single ST_TOO_LONG byte.
// Reset is synchronous and needs no clearing pass; it empties the dictionary.
// A stalled byte channel fills a two-entry output queue and then holds the
// sequencer; the next code is taken while earlier bytes still wait.
// ----------------------------------------------------------------------------
module lzw_code_decoder_top
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS  = 12,
  parameter int MAX_STRING_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             code_valid,
  output logic             code_stall,
  input  in_item_t         code_item,
  output logic             byte_valid,
  input  logic             byte_stall,
  output out_item_t        byte_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  lzwd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzwd_datapath #(
    .MAX_CODE_BITS  (MAX_CODE_BITS),
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .code_item  (code_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW code decoder. Codes are sent from a queue
// of pending items, and each accepted code is decoded by a behavioral model
// of the dictionary into the bytes it must produce. Every byte that comes out
// is checked against the oldest of those. Both channels idle at random, and
// the byte side holds off for long stretches to back the decoder up.
// ----------------------------------------------------------------------------
module tb;
  import lzwd_pkg::*;

  localparam int MAX_BITS     = 12;
  localparam int MAX_STRING   = 64;
  localparam int STORE_DEPTH  = (1 << MAX_BITS) - LITERALS;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 12;
  localparam int END_SETTLE   = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_CODES  = 19;
  localparam int RAMP_PHASE   = 3;
  localparam logic [CFG_W-1:0] BITS_PLAN [8] = '{
    4'd0, 4'd15, 4'd12, 4'd9, 4'd10, 4'd7, 4'd13, 4'd11
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             code_valid = 1'b0;
  logic             code_stall;
  in_item_t         code_item = '0;
  logic             byte_valid;
  logic             byte_stall = 1'b0;
  out_item_t        byte_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  lzw_code_decoder_top #(
    .MAX_CODE_BITS (MAX_BITS),
    .MAX_STRING_LEN(MAX_STRING)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code_item (code_item),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Dictionary model and its register copy.
  logic [11:0]      dict_prefix [STORE_DEPTH];
  logic [7:0]       dict_suffix [STORE_DEPTH];
  int unsigned      next_free = LITERALS;
  logic [11:0]      prev_code = '0;
  logic [7:0]       prev_first = '0;
  logic             have_prev = 1'b0;
  logic [CFG_W-1:0] code_bits_now = CODE_BITS_RESET;

  in_item_t  pending_codes [$];
  out_item_t expected_bytes [$];

  int unsigned gen_next = LITERALS;
  int          calm_left [2] = '{0, 0};
  int          code_gap = 0;
  int          byte_wait = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;

  int codes_in = 0, codes_queued = 0, bytes_seen = 0, cfg_writes = 0, holds_done = 0;
  int not_literal_seen = 0, too_long_seen = 0, unknown_seen = 0, full_seen = 0;
  int mismatches = 0, unexpected = 0, reported = 0;

  function automatic int unsigned dict_capacity();
    int unsigned b;
    b = code_bits_now;
    if (b < MIN_CODE_BITS) b = MIN_CODE_BITS;
    if (b > MAX_BITS) b = MAX_BITS;
    return 1 << b;
  endfunction

  // Waits come in runs of zero now and then, so back-to-back traffic happens.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm_left[side] = $urandom_range(4, 24);
    return $urandom_range(0, 17);
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic last,
                                      input result_status_t st);
    out_item_t r;
    r.out_byte  = b;
    r.last_byte = last;
    r.status    = st;
    expected_bytes.push_back(r);
  endfunction

  function automatic void predict_string(input in_item_t it);
    int unsigned c, n, lim, total, k;
    logic [7:0]  chain [MAX_STRING];
    logic [7:0]  first;
    bit          known, fits;
    if (it.stream_start || !have_prev) begin
      if (it.code_word >= LITERALS) begin
        expect_byte(8'h00, 1'b1, ST_NOT_LITERAL);
        not_literal_seen++;
        return;
      end
      next_free  = LITERALS;
      prev_code  = it.code_word;
      prev_first = it.code_word[7:0];
      have_prev  = 1'b1;
      expect_byte(it.code_word[7:0], 1'b1, ST_OK);
      return;
    end
    // A code beyond the dictionary is the previous string plus its first byte.
    known = it.code_word < next_free;
    c     = known ? it.code_word : prev_code;
    lim   = known ? MAX_STRING : MAX_STRING - 1;
    n     = 0;
    fits  = 1'b1;
    while (fits && c >= LITERALS) begin
      if (n >= lim) begin
        fits = 1'b0;
      end else begin
        chain[n] = dict_suffix[c - LITERALS];
        c = dict_prefix[c - LITERALS];
        n++;
      end
    end
    if (n >= lim) fits = 1'b0;
    if (!fits) begin
      expect_byte(8'h00, 1'b1, ST_TOO_LONG);
      too_long_seen++;
      return;
    end
    chain[n] = c[7:0];
    n++;
    first = known ? chain[n-1] : prev_first;
    total = known ? n : n + 1;
    for (k = 0; k < n; k++) expect_byte(chain[n-1-k], k == total - 1, ST_OK);
    if (!known) begin
      expect_byte(first, 1'b1, ST_OK);
      unknown_seen++;
    end
    if (next_free < dict_capacity()) begin
      dict_prefix[next_free - LITERALS] = prev_code;
      dict_suffix[next_free - LITERALS] = first;
      prev_code  = known ? it.code_word : 12'(next_free);
      prev_first = first;
      next_free++;
    end else begin
      full_seen++;
      if (known) begin
        prev_code  = it.code_word;
        prev_first = first;
      end
    end
  endfunction

  // Code side: an item stays put while stalled; a gap is drawn after each one is sent.
  always @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      code_gap = 0;
    end else begin
      if (code_valid && !code_stall) begin
        predict_string(code_item);
        codes_in++;
      end
      if (!code_valid || !code_stall) begin
        if (code_gap > 0) begin
          code_gap--;
          code_valid <= 1'b0;
        end else if (pending_codes.size() > 0) begin
          code_item  <= pending_codes.pop_front();
          code_valid <= 1'b1;
          code_gap = draw_wait(0);
        end else begin
          code_valid <= 1'b0;
        end
      end
    end
  end

  // Byte side: check each item, then stall for a drawn number of cycles.
  always @(posedge clk) begin : byte_side
    out_item_t want;
    if (rst) begin
      byte_stall <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          unexpected++;
          if (reported < 10)
            $display("unexpected byte %h last %b status %0d", byte_item.out_byte,
                     byte_item.last_byte, byte_item.status);
          reported++;
        end else begin
          want = expected_bytes.pop_front();
          if (byte_item.out_byte !== want.out_byte ||
              byte_item.last_byte !== want.last_byte ||
              byte_item.status !== want.status) begin
            mismatches++;
            if (reported < 10)
              $display("byte %0d: expected %h last %b status %0d, got %h last %b status %0d",
                       bytes_seen, want.out_byte, want.last_byte, want.status,
                       byte_item.out_byte, byte_item.last_byte, byte_item.status);
            reported++;
          end
        end
        byte_wait = draw_wait(1);
        // Two long hold-offs back the decoder up into its code input.
        if (bytes_seen == 150 || bytes_seen == 1200) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_stall <= 1'b1;
      end else if (byte_wait > 0) begin
        byte_wait--;
        byte_stall <= 1'b1;
      end else begin
        byte_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((code_valid && !code_stall) || (byte_valid && !byte_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d bytes outstanding", idle_cycles,
                 expected_bytes.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_code(input int unsigned code, input logic start);
    in_item_t it;
    it.code_word    = code[11:0];
    it.stream_start = start;
    pending_codes.push_back(it);
    codes_queued++;
  endtask

  // Every queued code must have been taken and every byte it causes checked.
  task automatic wait_drained(input int settle);
    do @(posedge clk);
    while (codes_in != codes_queued || expected_bytes.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_code_bits(input logic [CFG_W-1:0] bits);
    cfg_data  <= bits;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    code_bits_now = bits;
    cfg_writes++;
  endtask

  // Mostly well-formed continuation of the current stream, some fresh streams
  // and a little noise. gen_next tracks the dictionary size roughly.
  task automatic queue_random_codes(input int count);
    int          r;
    int unsigned code;
    logic        start;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (i == 0 && $urandom_range(0, 1) == 1) r = 0;
      if (r < 8) begin
        queue_code($urandom_range(0, LITERALS - 1), 1'b1);
        gen_next = LITERALS;
      end else if (r < 14) begin
        code  = $urandom_range(0, 4095);
        start = 1'($urandom_range(0, 1));
        queue_code(code, start);
        if (start && code < LITERALS) gen_next = LITERALS;
        else if (!start && gen_next < dict_capacity()) gen_next++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) code = $urandom_range(0, LITERALS - 1);
        else if (r < 80 && gen_next > LITERALS) code = $urandom_range(LITERALS, gen_next - 1);
        else if (r < 90) code = gen_next;
        else code = $urandom_range(gen_next, 4095);
        queue_code(code, 1'b0);
        if (gen_next < dict_capacity()) gen_next++;
      end
    end
  endtask

  initial begin
    int unsigned failures;
    int unsigned long_code;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: first-code rules, literals, known and unknown codes.
    @(negedge clk);
    queue_code(4095, 1'b0);
    queue_code(0, 1'b0);
    queue_code(255, 1'b0);
    queue_code(256, 1'b0);
    queue_code(258, 1'b0);
    queue_code(4095, 1'b0);
    queue_code(300, 1'b1);
    queue_code(170, 1'b1);
    queue_code(85, 1'b0);
    queue_code(256, 1'b0);
    wait_drained(SETTLE);

    // Directed: the smallest dictionary is full from the start.
    write_code_bits(4'd8);
    @(negedge clk);
    queue_code(60, 1'b1);
    queue_code(256, 1'b0);
    queue_code(18, 1'b0);
    queue_code(4095, 1'b0);
    queue_code(255, 1'b0);
    gen_next = LITERALS;

    for (int p = 0; p < 8; p++) begin
      wait_drained(SETTLE);
      write_code_bits(BITS_PLAN[p]);
      @(negedge clk);
      if (p == RAMP_PHASE) begin
        // Each unknown code lengthens the string by one byte until it no
        // longer fits; then a literal stores an entry one byte too long.
        queue_code($urandom_range(0, LITERALS - 1), 1'b1);
        gen_next = LITERALS;
        for (int k = 0; k < MAX_STRING - 1; k++) begin
          queue_code(gen_next, 1'b0);
          gen_next++;
        end
        queue_code(gen_next, 1'b0);
        queue_code($urandom_range(0, LITERALS - 1), 1'b0);
        long_code = gen_next;
        gen_next++;
        queue_code(long_code, 1'b0);
        queue_code(gen_next, 1'b0);
        gen_next++;
        queue_random_codes(4);
      end else begin
        queue_random_codes(PHASE_CODES);
      end
    end

    wait_drained(END_SETTLE);
    failures = mismatches + unexpected + expected_bytes.size();
    if (expected_bytes.size() != 0)
      $display("%0d expected bytes never arrived", expected_bytes.size());
    $display("run: %0d codes, %0d bytes, %0d register writes, %0d long hold-offs",
             codes_in, bytes_seen, cfg_writes, holds_done);
    $display("run: %0d bad first codes, %0d overlong, %0d unknown codes, %0d with full dict",
             not_literal_seen, too_long_seen, unknown_seen, full_seen);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d unexpected bytes", mismatches, unexpected);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_datapath.sv
src/lzwd_ctrl.sv
src/lzw_code_decoder_top.sv
tb/tb.sv
